/* rtl/sbd_pkg.sv */
`timescale 1ns / 1ps

package sbd_pkg;

   // frame layout
   localparam int FRAME_BYTES = 25;
   localparam int IDX_W       = 5;
   localparam logic [IDX_W-1:0] IDX_FIRST_DATA = 5'd1;
   localparam logic [IDX_W-1:0] IDX_LAST_DATA  = 5'd22;
   localparam logic [IDX_W-1:0] IDX_FAILSAFE   = 5'd23;
   localparam logic [IDX_W-1:0] IDX_END        = 5'(FRAME_BYTES - 1);
   localparam int FAILSAFE_BIT = 3;

   // channel unpacking
   localparam int CHAN_W  = 11;
   localparam int CH_IDX_W = 4;
   localparam logic [CH_IDX_W-1:0] CH_LAST = 4'd15;
   localparam int ACC_W   = 26;
   localparam int CNT_W   = 5;
   localparam logic [CNT_W-1:0] CNT_CHAN    = 5'(CHAN_W);
   localparam logic [CNT_W-1:0] CNT_BYTE    = 5'd8;
   localparam logic [CNT_W-1:0] CNT_RD_ROOM = 5'(ACC_W - 8);
   localparam logic [CNT_W-1:0] CNT_FULL    = 5'(ACC_W);

   // register map
   localparam logic CSR_START_BYTE = 1'b0;
   localparam logic CSR_END_BYTE   = 1'b1;
   localparam logic [7:0] START_BYTE_RST = 8'h0F;
   localparam logic [7:0] END_BYTE_RST   = 8'h00;

   // frame handoff to the unpacker
   typedef struct packed {
      logic go;
      logic failsafe;
   } start_type;

   // unpacker read request into the frame buffer
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } rd_req_type;

endpackage

/* rtl/sbd_unpack.sv */
`timescale 1ns / 1ps

module sbd_unpack
   import sbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  start_type        start,
   output logic             busy,
   output rd_req_type       rd_req,
   input  logic [7:0]       rd_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,  // [3:0] channel_index, [14:4] channel_value, [15] zero
   output logic             rsp_tuser,  // [0] failsafe
   output logic             rsp_tlast   // last_channel
);

   logic                busy_ff, busy_in;
   logic                fs_ff, fs_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    rd_byte_ff, rd_byte_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [CHAN_W-1:0]   out_val_ff, out_val_in;
   logic                out_fs_ff, out_fs_in;
   logic                out_last_ff, out_last_in;

   logic                slot_free;
   logic                consume;
   logic [CNT_W-1:0]    cnt_left;
   logic [CNT_W-1:0]    cnt_mid;
   logic [ACC_W-1:0]    acc_left;
   logic                issue;

   // a channel leaves when 11 bits are held and the output slot is free
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign consume   = busy_ff && (cnt_ff >= CNT_CHAN) && slot_free;

   // accumulator: drop consumed bits, append the byte read last cycle
   always_comb begin
      cnt_left = consume ? (cnt_ff - CNT_CHAN) : cnt_ff;
      acc_left = consume ? (acc_ff >> CHAN_W) : acc_ff;
      cnt_mid  = rd_pend_ff ? (cnt_left + CNT_BYTE) : cnt_left;
      issue    = busy_ff && (rd_byte_ff <= IDX_LAST_DATA) && (cnt_mid <= CNT_RD_ROOM);
   end

   // unpacker control and accumulator
   always_comb begin
      busy_in    = busy_ff;
      fs_in      = fs_ff;
      acc_in     = acc_left | (rd_pend_ff ? (ACC_W'(rd_data) << cnt_left) : '0);
      cnt_in     = cnt_mid;
      rd_byte_in = issue ? (rd_byte_ff + 5'd1) : rd_byte_ff;
      rd_pend_in = issue;
      ch_in      = consume ? (ch_ff + 4'd1) : ch_ff;
      if (consume && ch_ff == CH_LAST) begin
         busy_in = 1'b0;
      end
      if (start.go) begin
         busy_in    = 1'b1;
         fs_in      = start.failsafe;
         acc_in     = '0;
         cnt_in     = '0;
         rd_byte_in = IDX_FIRST_DATA;
         rd_pend_in = 1'b0;
         ch_in      = '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = consume || (rsp_valid_ff && !rsp_tready);
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_fs_in    = out_fs_ff;
      out_last_in  = out_last_ff;
      if (consume) begin
         out_idx_in  = ch_ff;
         out_val_in  = acc_ff[CHAN_W-1:0];
         out_fs_in   = fs_ff;
         out_last_in = (ch_ff == CH_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         cnt_ff       <= '0;
         rd_byte_ff   <= IDX_FIRST_DATA;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rd_pend_ff   <= rd_pend_in;
         cnt_ff       <= cnt_in;
         rd_byte_ff   <= rd_byte_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fs_ff       <= fs_in;
      acc_ff      <= acc_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_fs_ff   <= out_fs_in;
      out_last_ff <= out_last_in;
   end

   assign busy       = busy_ff;
   assign rd_req.en  = issue;
   assign rd_req.idx = rd_byte_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_val_ff, out_idx_ff};
   assign rsp_tuser  = out_fs_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("accumulator overfilled");

   a_last_drained: assert property (@(posedge clock) disable iff (reset)
      consume && ch_ff == CH_LAST |-> rd_byte_ff == IDX_LAST_DATA + 5'd1 && !rd_pend_ff
         && cnt_ff == CNT_CHAN)
      else $error("last channel left with frame bytes unread");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start.go |-> !busy_ff)
      else $error("frame handed over while unpacking");

endmodule

/* rtl/sbus_frame_decoder.sv */
`timescale 1ns / 1ps

// sbus frame decoder, 16 channels
// req channel: one received serial byte per beat in req_tdata. While idle the
// block waits for the start byte, then collects a 25-byte frame into one bank
// of a two-bank frame buffer. The end byte is checked as it arrives; a good
// frame is handed to the unpacker, a bad one is dropped. Either way the block
// goes back to waiting for a start byte.
// rsp channel: sixteen beats per good frame, channel 0 to 15, each with the
// frame's failsafe flag in rsp_tuser; rsp_tlast marks channel 15.
// csr channel: index 0 writes start_byte, index 1 writes end_byte; always ready.
// Throughput: one byte per cycle. While rsp is ready the unpacker reads the
// buffer one byte per cycle over its single read port and keeps up with
// frames sent back to back. req_tready drops only when a finished frame waits
// while the other bank is still being unpacked, i.e. when rsp is stalled.
// A stalled rsp holds its beat; the unpacker pauses behind the output register.
// Reset (synchronous) returns to idle, empties the unpacker and loads the
// register reset values 0x0F and 0x00; no buffer clearing is needed.

module sbus_frame_decoder
   import sbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] zero
   output logic        rsp_tuser,   // [0] failsafe
   output logic        rsp_tlast,   // last_channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]       start_byte_ff, start_byte_in;
   logic [7:0]       end_byte_ff, end_byte_in;
   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             wbank_ff, wbank_in;
   logic             ebank_ff, ebank_in;
   logic             pend_ff, pend_in;
   logic             fs_ff, fs_in;

   logic [7:0]       frame_mem_ff [2**(IDX_W+1)];
   logic [7:0]       rd_data_ff;

   logic             req_beat;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic             busy;
   start_type        start;
   rd_req_type       rd_req;

   // a waiting frame is taken this cycle when the unpacker is idle
   assign req_tready = !pend_ff || !busy;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // register writes
   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_BYTE: start_byte_in = csr_data;
            CSR_END_BYTE:   end_byte_in   = csr_data;
            default:        ;
         endcase
      end
   end

   // frame collection
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      fs_in       = fs_ff;
      wr_en       = 1'b0;
      wr_idx      = count_ff;
      if (req_beat) begin
         if (!in_frame_ff) begin
            if (req_tdata == start_byte_ff) begin
               wr_en       = 1'b1;
               wr_idx      = '0;
               count_in    = 5'd1;
               in_frame_in = 1'b1;
            end
         end else begin
            wr_en = 1'b1;
            if (count_ff == IDX_FAILSAFE) begin
               fs_in = req_tdata[FAILSAFE_BIT];
            end
            if (count_ff == IDX_END) begin
               in_frame_in = 1'b0;
               count_in    = '0;
               pend_in     = (req_tdata == end_byte_ff);
            end else begin
               count_in = count_ff + 5'd1;
            end
         end
      end
      if (start.go) begin
         pend_in = 1'b0;
      end
   end

   // hand a finished frame to the unpacker and swap banks
   always_comb begin
      start.go       = pend_ff && !busy;
      start.failsafe = fs_ff;
      wbank_in       = wbank_ff;
      ebank_in       = ebank_ff;
      if (start.go) begin
         wbank_in = !wbank_ff;
         ebank_in = wbank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         end_byte_ff   <= END_BYTE_RST;
         in_frame_ff   <= 1'b0;
         count_ff      <= '0;
         wbank_ff      <= 1'b0;
         ebank_ff      <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
         in_frame_ff   <= in_frame_in;
         count_ff      <= count_in;
         wbank_ff      <= wbank_in;
         ebank_ff      <= ebank_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      fs_ff <= fs_in;
   end

   // frame buffer: write port for the byte stream, read port for the unpacker
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[{wbank_ff, wr_idx}] <= req_tdata;
      end
      if (rd_req.en) begin
         rd_data_ff <= frame_mem_ff[{ebank_ff, rd_req.idx}];
      end
   end

   sbd_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rd_req     (rd_req),
      .rd_data    (rd_data_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      busy |-> wbank_ff != ebank_ff)
      else $error("collecting into the bank being unpacked");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !busy |=> !pend_ff && busy)
      else $error("finished frame not taken by the unpacker");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> count_ff == '0)
      else $error("byte count left over outside a frame");

endmodule
